// ----- sv/rle_pkg.sv -----
package rle_pkg;

    localparam int MAX_ROW_WIDTH = 1024;
    localparam int HIST_DEPTH    = 2 * MAX_ROW_WIDTH;
    localparam int HIST_AW       = $clog2(HIST_DEPTH);
    localparam int DIST_W        = $clog2(HIST_DEPTH) + 1;
    localparam int WIDTH_W       = $clog2(MAX_ROW_WIDTH) + 1;
    localparam int PIXELS_PER_RESULT = 16;
    localparam int LANE_W        = $clog2(PIXELS_PER_RESULT);
    localparam int CNT_W         = 10;
    localparam int POS_W         = 24;

    localparam logic [7:0] BYTE_ESC_LO  = 8'hF8;
    localparam logic [7:0] BYTE_ESC_HI  = 8'hFB;
    localparam logic [7:0] BYTE_PAIR    = 8'hFC;
    localparam logic [7:0] BYTE_RUN     = 8'hFD;
    localparam logic [7:0] BYTE_COPY2   = 8'hFE;
    localparam logic [7:0] BYTE_COPY1   = 8'hFF;

    localparam logic CFG_ROW_WIDTH    = 1'b0;
    localparam logic CFG_IMAGE_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        PH_CMD, PH_ESC, PH_PAIR_N, PH_PAIR_A, PH_PAIR_B, PH_RUN_N, PH_RUN_V, PH_COPY_N
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE, S_GEN, S_COPY_RD, S_COPY_WR
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } t_in_item;

    typedef struct packed {
        logic [63:0] pixels_low;
        logic [63:0] pixels_high;
        logic [4:0]  pixel_count;
        logic        image_done;
        logic        last;
    } t_out_item;

endpackage

// ----- sv/rle_row_copy_decoder_8bit.sv -----
// Decoder of a run-length and row-copy byte stream into 8-bit pixels, grouped
// sixteen to a result transfer. An input byte is taken only while no earlier
// byte is still producing pixels. A byte that only extends a command costs one
// cycle; a literal or escaped pixel costs two; a pair or plain run then emits
// one pixel per cycle; a row copy emits one pixel every two cycles, because
// the single history memory port must read the source pixel, and the pixel is
// written back before the next one is read. Pixel emission waits whenever a
// finished group still sits in the output register. History needs no clearing
// pass: a copy source before the current position minus the copy distance
// lies before the image and reads as zero, so reset and image start are free.
module rle_row_copy_decoder_8bit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rle_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rle_pkg::t_out_item   o_out_data
);

    // Configuration registers.
    logic [10:0]                    r_row_width;
    logic [rle_pkg::POS_W-1:0]      r_image_length;

    // Parser state.
    rle_pkg::t_phase                r_phase, n_phase;
    logic [7:0]                     r_cmd, n_cmd;
    logic [7:0]                     r_run_cnt, n_run_cnt;
    logic [7:0]                     r_first, n_first;
    logic [rle_pkg::POS_W-1:0]      r_pos, n_pos;

    // Pixel generator state.
    rle_pkg::t_state                r_state, n_state;
    logic [rle_pkg::CNT_W-1:0]      r_rem, n_rem;
    logic [7:0]                     r_val_a, n_val_a;
    logic [7:0]                     r_val_b, n_val_b;
    logic                           r_toggle, n_toggle;
    logic [rle_pkg::DIST_W-1:0]     r_dist, n_dist;
    logic                           r_before, n_before;

    // Group accumulator and output register.
    logic [7:0]                     r_acc [rle_pkg::PIXELS_PER_RESULT];
    logic [rle_pkg::LANE_W-1:0]     r_fill;
    logic                           r_out_valid;
    rle_pkg::t_out_item             r_out;

    // History memory with a registered read port.
    logic [7:0]                     r_hist [rle_pkg::HIST_DEPTH];
    logic [7:0]                     r_rd_data;
    logic                           rd_en;
    logic [rle_pkg::HIST_AW-1:0]    rd_addr;

    logic                           accept;
    logic                           can_emit;
    logic                           emit;
    logic [7:0]                     emit_pix;
    logic [rle_pkg::POS_W-1:0]      pos_inc;
    logic                           img_done;
    logic                           byte_end;
    logic                           close_grp;
    logic [7:0]                     grp [rle_pkg::PIXELS_PER_RESULT];
    rle_pkg::t_out_item             grp_item;
    logic [10:0]                    eff_width;
    logic [rle_pkg::POS_W-1:0]      start_pos;
    rle_pkg::t_phase                start_phase;
    logic [7:0]                     start_cmd, start_run, start_first;
    logic [7:0]                     b;

    assign o_in_ready  = (r_state == rle_pkg::S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A pixel may be produced only when a group it might close has somewhere to go.
    assign can_emit = !r_out_valid || i_out_ready;
    assign emit     = can_emit && ((r_state == rle_pkg::S_GEN) || (r_state == rle_pkg::S_COPY_WR));
    assign emit_pix = (r_state == rle_pkg::S_COPY_WR) ? (r_before ? 8'h00 : r_rd_data)
                    : (r_toggle ? r_val_b : r_val_a);
    assign pos_inc   = r_pos + 1'b1;
    assign img_done  = (pos_inc >= r_image_length);
    assign byte_end  = (r_rem == rle_pkg::CNT_W'(1)) || img_done;
    assign close_grp = emit && ((r_fill == {rle_pkg::LANE_W{1'b1}}) || byte_end);

    assign rd_en   = (r_state == rle_pkg::S_COPY_RD);
    assign rd_addr = rle_pkg::HIST_AW'(r_pos - rle_pkg::POS_W'(r_dist));

    assign eff_width = (r_row_width == 11'd0) ? 11'd1
                     : (r_row_width > 11'(rle_pkg::MAX_ROW_WIDTH))
                       ? 11'(rle_pkg::MAX_ROW_WIDTH) : r_row_width;

    // Current group with the new pixel dropped into its lane.
    always_comb begin
        for (int k = 0; k < rle_pkg::PIXELS_PER_RESULT; k++) begin
            grp[k] = r_acc[k];
        end
        grp[r_fill] = emit_pix;
        for (int k = 0; k < 8; k++) begin
            grp_item.pixels_low[8*k +: 8]  = grp[k];
            grp_item.pixels_high[8*k +: 8] = grp[k+8];
        end
        grp_item.pixel_count = 5'(r_fill) + 5'd1;
        grp_item.image_done  = img_done;
        grp_item.last        = byte_end;
    end

    // Byte parser and generator control.
    always_comb begin
        b           = i_in_data.data_byte;
        start_pos   = i_in_data.image_start ? '0 : r_pos;
        start_phase = i_in_data.image_start ? rle_pkg::PH_CMD : r_phase;
        start_cmd   = i_in_data.image_start ? 8'h00 : r_cmd;
        start_run   = i_in_data.image_start ? 8'h00 : r_run_cnt;
        start_first = i_in_data.image_start ? 8'h00 : r_first;

        n_phase   = r_phase;
        n_cmd     = r_cmd;
        n_run_cnt = r_run_cnt;
        n_first   = r_first;
        n_pos     = r_pos;
        n_state   = r_state;
        n_rem     = r_rem;
        n_val_a   = r_val_a;
        n_val_b   = r_val_b;
        n_toggle  = r_toggle;
        n_dist    = r_dist;
        n_before  = r_before;

        unique case (r_state)
            rle_pkg::S_IDLE: begin
                if (accept) begin
                    n_phase   = start_phase;
                    n_cmd     = start_cmd;
                    n_run_cnt = start_run;
                    n_first   = start_first;
                    n_pos     = start_pos;
                    n_val_a   = b;
                    n_val_b   = b;
                    n_toggle  = 1'b0;
                    n_rem     = rle_pkg::CNT_W'(1);
                    if (start_pos >= r_image_length) begin
                        n_phase = rle_pkg::PH_CMD;
                    end else begin
                        unique case (start_phase)
                            rle_pkg::PH_CMD: begin
                                if (b < rle_pkg::BYTE_ESC_LO) begin
                                    n_state = rle_pkg::S_GEN;
                                end else if (b <= rle_pkg::BYTE_ESC_HI) begin
                                    n_phase = rle_pkg::PH_ESC;
                                end else if (b == rle_pkg::BYTE_PAIR) begin
                                    n_cmd   = b;
                                    n_phase = rle_pkg::PH_PAIR_N;
                                end else if (b == rle_pkg::BYTE_RUN) begin
                                    n_cmd   = b;
                                    n_phase = rle_pkg::PH_RUN_N;
                                end else begin
                                    n_cmd   = b;
                                    n_phase = rle_pkg::PH_COPY_N;
                                end
                            end
                            rle_pkg::PH_ESC: begin
                                n_state = rle_pkg::S_GEN;
                                n_phase = rle_pkg::PH_CMD;
                            end
                            rle_pkg::PH_PAIR_N: begin
                                n_run_cnt = b;
                                n_phase   = rle_pkg::PH_PAIR_A;
                            end
                            rle_pkg::PH_PAIR_A: begin
                                n_first = b;
                                n_phase = rle_pkg::PH_PAIR_B;
                            end
                            rle_pkg::PH_PAIR_B: begin
                                n_val_a = start_first;
                                n_rem   = ({2'b00, start_run} + rle_pkg::CNT_W'(3)) << 1;
                                n_state = rle_pkg::S_GEN;
                                n_phase = rle_pkg::PH_CMD;
                            end
                            rle_pkg::PH_RUN_N: begin
                                n_run_cnt = b;
                                n_phase   = rle_pkg::PH_RUN_V;
                            end
                            rle_pkg::PH_RUN_V: begin
                                n_val_b = b;
                                n_rem   = {2'b00, start_run} + rle_pkg::CNT_W'(4);
                                n_state = rle_pkg::S_GEN;
                                n_phase = rle_pkg::PH_CMD;
                            end
                            rle_pkg::PH_COPY_N: begin
                                n_run_cnt = b;
                                n_rem     = {2'b00, b} + rle_pkg::CNT_W'(3);
                                n_dist    = (start_cmd == rle_pkg::BYTE_COPY2)
                                          ? {eff_width, 1'b0} : {1'b0, eff_width};
                                n_state   = rle_pkg::S_COPY_RD;
                                n_phase   = rle_pkg::PH_CMD;
                            end
                            default: n_phase = rle_pkg::PH_CMD;
                        endcase
                    end
                end
            end
            rle_pkg::S_COPY_RD: begin
                n_before = (r_pos < rle_pkg::POS_W'(r_dist));
                n_state  = rle_pkg::S_COPY_WR;
            end
            rle_pkg::S_GEN, rle_pkg::S_COPY_WR: begin
                if (emit) begin
                    n_pos    = pos_inc;
                    n_rem    = r_rem - 1'b1;
                    n_toggle = !r_toggle;
                    if (byte_end) begin
                        n_state = rle_pkg::S_IDLE;
                    end else if (r_state == rle_pkg::S_COPY_WR) begin
                        n_state = rle_pkg::S_COPY_RD;
                    end
                end
            end
            default: n_state = rle_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width    <= 11'd640;
            r_image_length <= 24'd307200;
            r_phase        <= rle_pkg::PH_CMD;
            r_cmd          <= 8'h00;
            r_run_cnt      <= 8'h00;
            r_first        <= 8'h00;
            r_pos          <= '0;
            r_state        <= rle_pkg::S_IDLE;
            r_fill         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rle_pkg::CFG_ROW_WIDTH:    r_row_width    <= i_cfg_data[10:0];
                    rle_pkg::CFG_IMAGE_LENGTH: r_image_length <= i_cfg_data;
                    default: ;
                endcase
            end
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_run_cnt <= n_run_cnt;
            r_first   <= n_first;
            r_pos     <= n_pos;
            r_state   <= n_state;
            if (close_grp) begin
                r_fill      <= '0;
                r_out_valid <= 1'b1;
            end else begin
                if (emit) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Payload registers; the accumulator clears its lanes when a group closes
    // so unused lanes of the next group read as zero.
    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_val_a  <= n_val_a;
        r_val_b  <= n_val_b;
        r_toggle <= n_toggle;
        r_dist   <= n_dist;
        r_before <= n_before;
        if (!i_rst_n || close_grp) begin
            for (int k = 0; k < rle_pkg::PIXELS_PER_RESULT; k++) begin
                r_acc[k] <= 8'h00;
            end
        end else if (emit) begin
            r_acc[r_fill] <= emit_pix;
        end
        if (close_grp) begin
            r_out <= grp_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_hist[rle_pkg::HIST_AW'(r_pos)] <= emit_pix;
        end
        if (rd_en) begin
            r_rd_data <= r_hist[rd_addr];
        end
    end

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.image_done |-> o_out_data.last)
        else $error("image_done without last");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pixel_count != 5'd0)
        else $error("empty result group");

    a_copy_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rle_pkg::S_COPY_WR |->
            $past(r_state) == rle_pkg::S_COPY_RD || $past(r_state) == rle_pkg::S_COPY_WR)
        else $error("copy write without a read before it");

    a_rem_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != rle_pkg::S_IDLE |-> r_rem != '0)
        else $error("generator active with nothing left");

endmodule

// ----- tb/rle_decoder_checker.sv -----
`timescale 1ns / 100ps

module rle_decoder_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [23:0]         i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  rle_pkg::t_in_item   i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  rle_pkg::t_out_item  i_out_data,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_groups_seen
);

    logic [10:0] row_width;
    logic [23:0] image_length;
    logic [7:0]  history [rle_pkg::HIST_DEPTH];
    rle_pkg::t_phase phase;
    logic [7:0]  cmd_code;
    logic [7:0]  run_len;
    logic [7:0]  pair_first;
    logic [23:0] position;

    rle_pkg::t_out_item pixel_groups [$];
    rle_pkg::t_out_item open_group;
    int          open_fill;
    int          groups_this_byte;

    assign o_pending = pixel_groups.size();

    function automatic int eff_width();
        int w;
        w = int'(row_width);
        if (w == 0) w = 1;
        if (w > rle_pkg::MAX_ROW_WIDTH) w = rle_pkg::MAX_ROW_WIDTH;
        return w;
    endfunction

    task automatic clear_image();
        for (int k = 0; k < rle_pkg::HIST_DEPTH; k++)
            history[rle_pkg::HIST_AW'(k)] = 8'h00;
        phase      = rle_pkg::PH_CMD;
        cmd_code   = 8'h00;
        run_len    = 8'h00;
        pair_first = 8'h00;
        position   = 24'd0;
    endtask

    task automatic close_group(input logic done);
        if (open_fill != 0) begin
            open_group.pixel_count = 5'(open_fill);
            open_group.image_done  = done;
            open_group.last        = 1'b0;
            pixel_groups.push_back(open_group);
            groups_this_byte++;
            open_fill = 0;
        end
    endtask

    task automatic put_pixel(input logic [7:0] p);
        if (position < image_length) begin
            history[rle_pkg::HIST_AW'(position)] = p;
            position = position + 24'd1;
            if (open_fill == 0) open_group = '0;
            if (open_fill >= 8) open_group.pixels_high[8 * (open_fill - 8) +: 8] = p;
            else open_group.pixels_low[8 * open_fill +: 8] = p;
            open_fill++;
            if (position >= image_length) close_group(1'b1);
            else if (open_fill == rle_pkg::PIXELS_PER_RESULT) close_group(1'b0);
        end
    endtask

    task automatic decode_byte(input rle_pkg::t_in_item it);
        int n;
        int d;
        logic [7:0] b;
        b = it.data_byte;
        if (it.image_start) clear_image();
        open_fill = 0;
        groups_this_byte = 0;
        if (position >= image_length) begin
            phase = rle_pkg::PH_CMD;
            return;
        end
        unique case (phase)
            rle_pkg::PH_CMD: begin
                if (b < rle_pkg::BYTE_ESC_LO) put_pixel(b);
                else if (b <= rle_pkg::BYTE_ESC_HI) phase = rle_pkg::PH_ESC;
                else begin
                    cmd_code = b;
                    if (b == rle_pkg::BYTE_PAIR) phase = rle_pkg::PH_PAIR_N;
                    else if (b == rle_pkg::BYTE_RUN) phase = rle_pkg::PH_RUN_N;
                    else phase = rle_pkg::PH_COPY_N;
                end
            end
            rle_pkg::PH_ESC: begin
                put_pixel(b);
                phase = rle_pkg::PH_CMD;
            end
            rle_pkg::PH_PAIR_N: begin
                run_len = b;
                phase = rle_pkg::PH_PAIR_A;
            end
            rle_pkg::PH_PAIR_A: begin
                pair_first = b;
                phase = rle_pkg::PH_PAIR_B;
            end
            rle_pkg::PH_PAIR_B: begin
                n = 2 * (int'(run_len) + 3);
                for (int k = 0; k < n && position < image_length; k++)
                    put_pixel(k[0] ? b : pair_first);
                phase = rle_pkg::PH_CMD;
            end
            rle_pkg::PH_RUN_N: begin
                run_len = b;
                phase = rle_pkg::PH_RUN_V;
            end
            rle_pkg::PH_RUN_V: begin
                n = int'(run_len) + 4;
                for (int k = 0; k < n && position < image_length; k++) put_pixel(b);
                phase = rle_pkg::PH_CMD;
            end
            default: begin
                run_len = b;
                d = eff_width();
                if (cmd_code == rle_pkg::BYTE_COPY2) d = 2 * d;
                n = int'(b) + 3;
                for (int k = 0; k < n && position < image_length; k++)
                    put_pixel(history[rle_pkg::HIST_AW'(int'(position) - d)]);
                phase = rle_pkg::PH_CMD;
            end
        endcase
        close_group(1'b0);
        if (groups_this_byte > 0) pixel_groups[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        rle_pkg::t_out_item want;
        if (!i_rst_n) begin
            row_width     = 11'd640;
            image_length  = 24'd307200;
            clear_image();
            pixel_groups.delete();
            o_fail_count  = 0;
            o_groups_seen = 0;
        end else begin
            // A result transfer is compared before the input transfer of the
            // same edge is predicted, so each group meets only older bytes.
            if (i_out_valid && i_out_ready) begin
                o_groups_seen++;
                if (pixel_groups.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected pixel group %p", i_out_data);
                end else begin
                    want = pixel_groups.pop_front();
                    if (i_out_data !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("pixel group mismatch: expected %p, got %p",
                                     want, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) decode_byte(i_in_data);
            if (i_cfg_we) begin
                if (i_cfg_index == rle_pkg::CFG_ROW_WIDTH) row_width = i_cfg_data[10:0];
                else image_length = i_cfg_data;
            end
        end
    end

endmodule

// ----- tb/tb_rle_row_copy_decoder_8bit.sv -----
`timescale 1ns / 100ps

module tb_rle_row_copy_decoder_8bit;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = rle_pkg::CFG_ROW_WIDTH;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    rle_pkg::t_in_item  in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    rle_pkg::t_out_item out_data;

    int          fail_count;
    int          pending;
    int          groups_seen;
    int          bytes_sent = 0;
    bit          long_hold = 1'b0;
    bit          sink_free_run = 1'b0;

    rle_row_copy_decoder_8bit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    rle_decoder_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_groups_seen (groups_seen)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Sends one byte: a random gap first, then valid is held until the
    // transfer happens on a rising edge. All drives happen at falling edges.
    task automatic send_byte(input logic [7:0] b, input logic start, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, image_start: start};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
        in_valid <= 1'b0;
    endtask

    // Configuration is written only while idle: all groups in, plus a margin
    // for a command byte that may still be in flight inside the block.
    task automatic write_reg(input logic idx, input logic [23:0] val);
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // A random byte sequence, mostly well-formed commands with random content.
    task automatic send_command(input logic start);
        int kind;
        logic [7:0] op;
        kind = $urandom_range(0, 9);
        if (kind < 3) send_byte(8'($urandom_range(0, 8'hF7)), start, 0);
        else if (kind == 3) begin
            send_byte(8'($urandom_range(rle_pkg::BYTE_ESC_LO, rle_pkg::BYTE_ESC_HI)), start, 0);
            send_byte(8'($urandom), 1'b0, 0);
        end else if (kind == 4) begin
            send_byte(rle_pkg::BYTE_PAIR, start, 0);
            send_byte(8'($urandom_range(0, 20)), 1'b0, 0);
            send_byte(8'($urandom), 1'b0, 0);
            send_byte(8'($urandom), 1'b0, 0);
        end else if (kind == 5) begin
            send_byte(rle_pkg::BYTE_RUN, start, 0);
            send_byte(8'($urandom_range(0, 30)), 1'b0, 0);
            send_byte(8'($urandom), 1'b0, 0);
        end else if (kind < 9) begin
            op = $urandom_range(0, 1) ? rle_pkg::BYTE_COPY1 : rle_pkg::BYTE_COPY2;
            send_byte(op, start, 0);
            send_byte(8'($urandom_range(0, 40)), 1'b0, 0);
        end else begin
            // Noise, occasionally with a stray image start in mid-command.
            send_byte(8'($urandom), $urandom_range(0, 15) == 0, 0);
        end
    endtask

    // The receiver draws a stall per group; during the long hold it stays off, in free run it stays on.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) out_ready <= 1'b0;
            else if (sink_free_run) out_ready <= 1'b1;
            else begin
                stall = $urandom_range(0, 19);
                if ($urandom_range(0, 3) == 0) stall = 0;
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                out_ready <= 1'b1;
                @(posedge i_clk);
                while (!out_valid) @(posedge i_clk);
            end
        end
    end

    initial begin
        #2000000;
        $display("rle_row_copy_decoder_8bit verification failed");
        $finish;
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset geometry first, then a small image and corner cases.
        send_byte(8'h00, 1'b1, 0);
        send_byte(8'hF7, 1'b0, 0);
        send_byte(rle_pkg::BYTE_COPY1, 1'b0, 0);
        send_byte(8'h00, 1'b0, 0);
        write_reg(rle_pkg::CFG_ROW_WIDTH, 24'd4);
        write_reg(rle_pkg::CFG_IMAGE_LENGTH, 24'd40);
        send_byte(8'h11, 1'b1, 0);
        send_byte(rle_pkg::BYTE_COPY2, 1'b0, 0);
        send_byte(8'h05, 1'b0, 0);
        send_byte(rle_pkg::BYTE_ESC_LO, 1'b0, 0);
        send_byte(8'hFF, 1'b0, 0);
        send_byte(rle_pkg::BYTE_ESC_HI, 1'b0, 0);
        send_byte(8'hFC, 1'b0, 0);
        send_byte(rle_pkg::BYTE_PAIR, 1'b0, 0);
        send_byte(8'h00, 1'b0, 0);
        send_byte(8'hAA, 1'b0, 0);
        send_byte(8'h55, 1'b0, 0);
        send_byte(rle_pkg::BYTE_RUN, 1'b0, 0);
        send_byte(8'hFF, 1'b0, 0);
        send_byte(8'h3C, 1'b0, 0);
        send_byte(8'h01, 1'b0, 0);
        // Image start in mid-command abandons the run.
        send_byte(rle_pkg::BYTE_RUN, 1'b1, 0);
        send_byte(8'h7E, 1'b1, 0);
        send_byte(rle_pkg::BYTE_COPY1, 1'b0, 0);
        send_byte(8'h40, 1'b0, 0);

        // Odd widths: zero acts as one, above the maximum acts as the maximum.
        write_reg(rle_pkg::CFG_ROW_WIDTH, 24'd0);
        write_reg(rle_pkg::CFG_IMAGE_LENGTH, 24'd1);
        send_byte(8'h22, 1'b1, 0);
        send_byte(8'h23, 1'b0, 0);
        write_reg(rle_pkg::CFG_IMAGE_LENGTH, 24'd300);
        send_byte(8'h09, 1'b1, 0);
        send_byte(rle_pkg::BYTE_COPY1, 1'b0, 0);
        send_byte(8'h20, 1'b0, 0);
        write_reg(rle_pkg::CFG_ROW_WIDTH, 24'd2047);

        // Random images, small geometry redrawn every fourth one; the long hold fills the block.
        for (int img = 0; bytes_sent < 180; img++) begin
            if (img % 4 == 3) begin
                write_reg(rle_pkg::CFG_ROW_WIDTH, 24'($urandom_range(1, 24)));
                write_reg(rle_pkg::CFG_IMAGE_LENGTH, 24'($urandom_range(20, 400)));
            end
            if (img == 2) begin
                long_hold = 1'b1;
                fork
                    begin
                        repeat (300) @(negedge i_clk);
                        long_hold = 1'b0;
                    end
                join_none
            end
            if (img == 4) begin
                while (pending != 0) @(negedge i_clk);
                sink_free_run = 1'b1;
            end
            if (img == 5) sink_free_run = 1'b0;
            send_command(1'b1);
            for (int k = 0; k < 12; k++) send_command(1'b0);
        end
        write_reg(rle_pkg::CFG_ROW_WIDTH, 24'd1024);
        write_reg(rle_pkg::CFG_IMAGE_LENGTH, 24'hFFFFFF);
        for (int k = 0; k < 10; k++) send_command(k == 0);

        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("Sent %0d stream bytes and checked %0d pixel groups", bytes_sent, groups_seen);
        $display("over literals, escapes, pair and plain runs, row copies and image ends.");
        if (fail_count == 0 && pending == 0) begin
            $display("rle_row_copy_decoder_8bit verification clean");
        end else begin
            $display("rle_row_copy_decoder_8bit verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/rle_pkg.sv
sv/rle_row_copy_decoder_8bit.sv
tb/rle_decoder_checker.sv
tb/tb_rle_row_copy_decoder_8bit.sv
